[rtl/core/cv2d_pkg.sv]
// ----------------------------------------------------------------------------
// cv2d_pkg: shared types and constants
// Widths, default limits, register indexes and the cell chain control group.
// ----------------------------------------------------------------------------
package cv2d_pkg;

    localparam int DATA_W              = 32;
    localparam int DEF_MAX_IMAGE_COLS  = 1024;
    localparam int DEF_MAX_KERNEL_ROWS = 8;
    localparam int DEF_MAX_KERNEL_COLS = 8;
    localparam int ROWS_LIMIT          = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 2'd3;

    // input action carried in tuser
    localparam logic ACT_KERNEL = 1'b0;
    localparam logic ACT_PIXEL  = 1'b1;

    // chain control: shift pixel/weight pairs in, multiply, drain products, clear the accumulator
    typedef struct packed {
        logic shift;
        logic mul;
        logic drain;
        logic clear;
    } chain_ctrl_t;

endpackage

[rtl/core/cv2d_cell.sv]
// ----------------------------------------------------------------------------
// cv2d_cell: one multiply cell of the chain
// Holds a pixel/weight pair and its product; pairs move up, products move down.
// ----------------------------------------------------------------------------
module cv2d_cell
    import cv2d_pkg::*;
(
    input  logic              aclk,
    input  chain_ctrl_t       ctrl,
    input  logic [DATA_W-1:0] pix_in,
    input  logic [DATA_W-1:0] wgt_in,
    input  logic [DATA_W-1:0] prod_in,
    output logic [DATA_W-1:0] pix_out,
    output logic [DATA_W-1:0] wgt_out,
    output logic [DATA_W-1:0] prod_out
);

    logic [DATA_W-1:0] pix_reg;
    logic [DATA_W-1:0] wgt_reg;
    logic [DATA_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            pix_reg <= pix_in;
            wgt_reg <= wgt_in;
        end
        if (ctrl.mul) begin
            prod_reg <= pix_reg * wgt_reg;   // low 32 bits, wraps
        end else if (ctrl.drain) begin
            prod_reg <= prod_in;
        end
    end

    assign pix_out  = pix_reg;
    assign wgt_out  = wgt_reg;
    assign prod_out = prod_reg;

endmodule

[rtl/core/cv2d_chain.sv]
// ----------------------------------------------------------------------------
// cv2d_chain: row of multiply cells with the window accumulator
// Cell 0 takes pairs from the stores and hands its product to the accumulator.
// ----------------------------------------------------------------------------
module cv2d_chain
    import cv2d_pkg::*;
#(
    parameter int NUM_CELLS = DEF_MAX_KERNEL_COLS
) (
    input  logic              aclk,
    input  chain_ctrl_t       ctrl,
    input  logic [DATA_W-1:0] pix_in,
    input  logic [DATA_W-1:0] wgt_in,
    output logic [DATA_W-1:0] acc_out
);

    logic [DATA_W-1:0] pix_w  [NUM_CELLS];
    logic [DATA_W-1:0] wgt_w  [NUM_CELLS];
    logic [DATA_W-1:0] prod_w [NUM_CELLS];
    logic [DATA_W-1:0] acc_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_cell
            logic [DATA_W-1:0] p_in;
            logic [DATA_W-1:0] w_in;
            logic [DATA_W-1:0] q_in;
            if (g == 0) begin : g_head
                assign p_in = pix_in;
                assign w_in = wgt_in;
            end else begin : g_body
                assign p_in = pix_w[g-1];
                assign w_in = wgt_w[g-1];
            end
            if (g == NUM_CELLS - 1) begin : g_top
                assign q_in = '0;
            end else begin : g_mid
                assign q_in = prod_w[g+1];
            end
            cv2d_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .pix_in   (p_in),
                .wgt_in   (w_in),
                .prod_in  (q_in),
                .pix_out  (pix_w[g]),
                .wgt_out  (wgt_w[g]),
                .prod_out (prod_w[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.drain) begin
            acc_reg <= acc_reg + prod_w[0];
        end
    end

    assign acc_out = acc_reg;

endmodule

[rtl/core/conv2d_valid_int32.sv]
// ----------------------------------------------------------------------------
// conv2d_valid_int32: valid-mode 2D convolution, 32-bit wrapping sums
// Kernel element or pixel without a full window: accepted in idle, stays idle.
// Pixel completing a window: input is held off until the sum enters the result
// register, which waits until it is free. Each window row costs kc line-store
// reads (one read port), a multiply step and kc products drained through the chain.
// Reset: synchronous, active low; registers to 1, positions to zero.
// ----------------------------------------------------------------------------
module conv2d_valid_int32
    import cv2d_pkg::*;
#(
    parameter int MAX_IMAGE_COLS  = DEF_MAX_IMAGE_COLS,
    parameter int MAX_KERNEL_ROWS = DEF_MAX_KERNEL_ROWS,
    parameter int MAX_KERNEL_COLS = DEF_MAX_KERNEL_COLS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // [31:0] value
    input  logic                  s_tuser,   // [0] action: 0 kernel, 1 pixel
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // [31:0] out_value
    output logic                  m_tlast,   // out_last
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int KDEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
    localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int KKW    = $clog2(KDEPTH + 1);
    localparam int LDEPTH = MAX_KERNEL_ROWS * MAX_IMAGE_COLS;
    localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int CW     = $clog2(MAX_IMAGE_COLS + 1);
    localparam int RW     = 12;
    localparam int ERW    = 13;
    localparam int KRW    = $clog2(MAX_KERNEL_ROWS + 1);
    localparam int KCW    = $clog2(MAX_KERNEL_COLS + 1);
    localparam int SW     = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
    localparam int TW     = SW + KRW + 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROW, ST_ISSUE, ST_LAST, ST_MUL, ST_DRAIN, ST_FIN
    } state_t;

    // configuration registers
    logic [12:0] image_rows_reg;
    logic [10:0] image_cols_reg;
    logic [3:0]  kernel_rows_reg;
    logic [3:0]  kernel_cols_reg;

    // effective (clamped) sizes
    logic [ERW-1:0] rows_eff;
    logic [CW-1:0]  cols_eff;
    logic [KRW-1:0] kr_eff;
    logic [KCW-1:0] kc_eff;
    logic [KKW-1:0] kk_eff;

    always_comb begin
        if (image_rows_reg == '0) begin
            rows_eff = ERW'(1);
        end else if (32'(image_rows_reg) > 32'(ROWS_LIMIT)) begin
            rows_eff = ERW'(ROWS_LIMIT);
        end else begin
            rows_eff = ERW'(image_rows_reg);
        end
        if (image_cols_reg == '0) begin
            cols_eff = CW'(1);
        end else if (32'(image_cols_reg) > 32'(MAX_IMAGE_COLS)) begin
            cols_eff = CW'(MAX_IMAGE_COLS);
        end else begin
            cols_eff = CW'(image_cols_reg);
        end
        if (kernel_rows_reg == '0) begin
            kr_eff = KRW'(1);
        end else if (32'(kernel_rows_reg) > 32'(MAX_KERNEL_ROWS)) begin
            kr_eff = KRW'(MAX_KERNEL_ROWS);
        end else begin
            kr_eff = KRW'(kernel_rows_reg);
        end
        if (kernel_cols_reg == '0) begin
            kc_eff = KCW'(1);
        end else if (32'(kernel_cols_reg) > 32'(MAX_KERNEL_COLS)) begin
            kc_eff = KCW'(MAX_KERNEL_COLS);
        end else begin
            kc_eff = KCW'(kernel_cols_reg);
        end
    end

    assign kk_eff = KKW'(32'(kr_eff) * 32'(kc_eff));

    // control state
    state_t         state_reg;
    logic [KAW-1:0] kidx_reg;      // kernel load position
    logic [RW-1:0]  row_reg;       // pixel position
    logic [CW-1:0]  col_reg;
    logic [SW-1:0]  wslot_reg;     // row_reg mod MAX_KERNEL_ROWS
    logic [SW-1:0]  rslot_reg;     // line-store slot of current window row
    logic [CW-1:0]  c0_reg;        // window left column
    logic           last_reg;
    logic [LAW-1:0] lbase_reg;
    logic [KAW-1:0] kaddr_reg;
    logic [KCW-1:0] jcnt_reg;
    logic [KRW-1:0] icnt_reg;
    logic           issue_d_reg;
    logic           m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic           m_tlast_reg;

    // memories
    logic [DATA_W-1:0] kmem [KDEPTH];
    logic [DATA_W-1:0] lmem [LDEPTH];
    logic [DATA_W-1:0] krd_reg;
    logic [DATA_W-1:0] lrd_reg;

    logic              s_xfer;
    logic              cfg_xfer;
    logic              pix_xfer;
    logic              ker_xfer;
    logic              window;
    logic [LAW-1:0]    waddr;
    logic [LAW-1:0]    raddr;
    logic [TW-1:0]     top_slot;
    logic              out_load;
    chain_ctrl_t       ctrl;
    logic [DATA_W-1:0] acc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign pix_xfer  = s_xfer && (s_tuser == ACT_PIXEL);
    assign ker_xfer  = s_xfer && (s_tuser == ACT_KERNEL);

    // window complete when r+1 >= kr and c+1 >= kc
    assign window = (32'(row_reg) + 32'd1 >= 32'(kr_eff)) &&
                    (32'(col_reg) + 32'd1 >= 32'(kc_eff));

    assign waddr = LAW'(int'(wslot_reg) * MAX_IMAGE_COLS + int'(col_reg));
    assign raddr = lbase_reg + LAW'(jcnt_reg);

    // slot of the window's top row: (wslot + 1 - kr) mod MAX_KERNEL_ROWS
    always_comb begin
        top_slot = TW'(wslot_reg) + TW'(MAX_KERNEL_ROWS + 1) - TW'(kr_eff);
        if (top_slot >= TW'(MAX_KERNEL_ROWS)) begin
            top_slot = top_slot - TW'(MAX_KERNEL_ROWS);
        end
    end

    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    // memory ports: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (ker_xfer) begin
            kmem[kidx_reg] <= s_tdata;
        end
        krd_reg <= kmem[kaddr_reg];
        if (pix_xfer) begin
            lmem[waddr] <= s_tdata;
        end
        lrd_reg <= lmem[raddr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            image_rows_reg  <= 13'd1;
            image_cols_reg  <= 11'd1;
            kernel_rows_reg <= 4'd1;
            kernel_cols_reg <= 4'd1;
            kidx_reg        <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            wslot_reg       <= '0;
            issue_d_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            issue_d_reg <= (state_reg == ST_ISSUE);
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_xfer) begin
                case (cfg_index)
                    CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data;
                    CFG_IMAGE_COLS:  image_cols_reg  <= cfg_data[10:0];
                    CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[3:0];
                    CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[3:0];
                    default: ;
                endcase
                // any write restarts loading
                kidx_reg  <= '0;
                row_reg   <= '0;
                col_reg   <= '0;
                wslot_reg <= '0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (ker_xfer && !cfg_xfer) begin
                        if (KKW'(kidx_reg) + KKW'(1) >= kk_eff) begin
                            kidx_reg <= '0;
                        end else begin
                            kidx_reg <= kidx_reg + KAW'(1);
                        end
                    end
                    if (pix_xfer) begin
                        rslot_reg <= SW'(top_slot);
                        c0_reg    <= col_reg + CW'(1) - CW'(kc_eff);
                        last_reg  <= (32'(row_reg) + 32'd1 == 32'(rows_eff)) &&
                                     (col_reg + CW'(1) == cols_eff);
                        kaddr_reg <= KAW'(kk_eff - KKW'(1));
                        icnt_reg  <= '0;
                        if (!cfg_xfer) begin
                            if (col_reg + CW'(1) >= cols_eff) begin
                                col_reg <= '0;
                                if (32'(row_reg) + 32'd1 >= 32'(rows_eff)) begin
                                    row_reg   <= '0;
                                    wslot_reg <= '0;
                                end else begin
                                    row_reg <= row_reg + RW'(1);
                                    if (32'(wslot_reg) + 1 >= MAX_KERNEL_ROWS) begin
                                        wslot_reg <= '0;
                                    end else begin
                                        wslot_reg <= wslot_reg + SW'(1);
                                    end
                                end
                            end else begin
                                col_reg <= col_reg + CW'(1);
                            end
                        end
                        if (window) begin
                            state_reg <= ST_ROW;
                        end
                    end
                end
                ST_ROW: begin
                    lbase_reg <= LAW'(int'(rslot_reg) * MAX_IMAGE_COLS + int'(c0_reg));
                    jcnt_reg  <= '0;
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    jcnt_reg  <= jcnt_reg + KCW'(1);
                    kaddr_reg <= kaddr_reg - KAW'(1);
                    if (jcnt_reg + KCW'(1) >= kc_eff) begin
                        state_reg <= ST_LAST;
                    end
                end
                ST_LAST: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    jcnt_reg  <= '0;
                    state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    jcnt_reg <= jcnt_reg + KCW'(1);
                    if (jcnt_reg + KCW'(1) >= kc_eff) begin
                        if (icnt_reg + KRW'(1) >= kr_eff) begin
                            state_reg <= ST_FIN;
                        end else begin
                            icnt_reg <= icnt_reg + KRW'(1);
                            if (32'(rslot_reg) + 1 >= MAX_KERNEL_ROWS) begin
                                rslot_reg <= '0;
                            end else begin
                                rslot_reg <= rslot_reg + SW'(1);
                            end
                            state_reg <= ST_ROW;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= acc;
            m_tlast_reg <= last_reg;
        end
    end

    // chain control
    always_comb begin
        ctrl.shift = issue_d_reg;
        ctrl.mul   = (state_reg == ST_MUL);
        ctrl.drain = (state_reg == ST_DRAIN);
        ctrl.clear = pix_xfer;
    end

    cv2d_chain #(
        .NUM_CELLS (MAX_KERNEL_COLS)
    ) u_chain (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .pix_in  (lrd_reg),
        .wgt_in  (krd_reg),
        .acc_out (acc)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // kernel load position stays inside the loaded kernel
    a_kidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        KKW'(kidx_reg) < kk_eff)
        else $error("kernel index beyond kernel size");

    // pixel position stays inside the image
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg < cols_eff) && (32'(row_reg) < 32'(rows_eff)))
        else $error("pixel position beyond image");

    // a window is only started from idle on a pixel transfer
    a_row_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && !pix_xfer |=> state_reg == ST_IDLE)
        else $error("window work started without a pixel");

    // result register is loaded only when free or being drained
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> $stable(m_tdata_reg))
        else $error("pending result overwritten");

endmodule

[tb/sv/conv2d_valid_int32_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv2d_valid_int32_check: stream checker for the 2D valid convolution
// Watches config, input and result transfers, keeps its own kernel and line
// store, predicts each window sum and compares it with the result stream.
// ----------------------------------------------------------------------------
module conv2d_valid_int32_check
    import cv2d_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DATA_W-1:0]     m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fails,
    output int                    pending,
    output int                    results_seen
);

    localparam int KDEPTH = DEF_MAX_KERNEL_ROWS * DEF_MAX_KERNEL_COLS;
    localparam int LDEPTH = DEF_MAX_KERNEL_ROWS * DEF_MAX_IMAGE_COLS;

    typedef struct {
        logic [31:0] sum;
        logic        last;
    } window_t;

    window_t     sums_q[$];
    logic [12:0] reg_rows;
    logic [10:0] reg_cols;
    logic [3:0]  reg_kr, reg_kc;
    logic [31:0] kern[KDEPTH];
    logic [31:0] lines[LDEPTH];
    int          kidx, prow, pcol;

    function automatic int clamp(int v, int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    task automatic take_item(logic act, logic [31:0] v);
        int rows, cols, kr, kc, r, c, r0, c0, slot;
        logic [31:0] acc;
        window_t w;
        rows = clamp(reg_rows, ROWS_LIMIT);
        cols = clamp(reg_cols, DEF_MAX_IMAGE_COLS);
        kr   = clamp(reg_kr, DEF_MAX_KERNEL_ROWS);
        kc   = clamp(reg_kc, DEF_MAX_KERNEL_COLS);
        if (act == ACT_KERNEL) begin
            if (kidx < KDEPTH) kern[kidx] = v;
            kidx++;
            if (kidx >= kr * kc) kidx = 0;
            return;
        end
        r = (prow >= rows) ? 0 : prow;
        c = (pcol >= cols) ? 0 : pcol;
        lines[(r % DEF_MAX_KERNEL_ROWS) * DEF_MAX_IMAGE_COLS + c] = v;
        if (r + 1 >= kr && c + 1 >= kc) begin
            r0 = r + 1 - kr;
            c0 = c + 1 - kc;
            acc = '0;
            for (int i = 0; i < kr; i++) begin
                slot = ((r0 + i) % DEF_MAX_KERNEL_ROWS) * DEF_MAX_IMAGE_COLS;
                for (int j = 0; j < kc; j++)
                    acc += lines[slot + c0 + j] * kern[(kr - 1 - i) * kc + (kc - 1 - j)];
            end
            w.sum  = acc;
            w.last = (r + 1 == rows && c + 1 == cols);
            sums_q.push_back(w);
        end
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end
        prow = r;
        pcol = c;
    endtask

    always @(posedge aclk) begin
        window_t w;
        if (!aresetn) begin
            sums_q.delete();
            reg_rows = 1; reg_cols = 1; reg_kr = 1; reg_kc = 1;
            kidx = 0; prow = 0; pcol = 0;
            fails = 0;
            results_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (sums_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    fails++;
                end else begin
                    w = sums_q.pop_front();
                    if (m_tdata !== w.sum) begin
                        $display("%0t: sum mismatch, expected %h, actual %h",
                                 $time, w.sum, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== w.last) begin
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, w.last, m_tlast);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_ROWS:  reg_rows = cfg_data[12:0];
                    CFG_IMAGE_COLS:  reg_cols = cfg_data[10:0];
                    CFG_KERNEL_ROWS: reg_kr   = cfg_data[3:0];
                    CFG_KERNEL_COLS: reg_kc   = cfg_data[3:0];
                    default: ;
                endcase
                kidx = 0; prow = 0; pcol = 0;
            end
            if (s_tvalid && s_tready) take_item(s_tuser, s_tdata);
        end
        pending = sums_q.size();
    end

endmodule

[tb/sv/conv2d_valid_int32_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv2d_valid_int32_test: top of the convolution testbench
// Programs image and kernel sizes, loads kernels, streams pixels with random
// gaps and backpressure; the checker predicts and compares every sum.
// ----------------------------------------------------------------------------
module conv2d_valid_int32_test;
    import cv2d_pkg::*;

    localparam int SETTLE     = 200;   // longer than the worst window latency
    localparam int ITEM_GOAL  = 1850;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0, s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid, m_tready = 1'b0, m_tlast;
    logic [DATA_W-1:0]     m_tdata;
    logic                  cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fails, pending, results_seen;
    int items_sent = 0;
    int phases     = 0;
    bit calm       = 1'b0;   // no idling on either side while set
    bit stall_req  = 1'b0;   // ask the receiver for one long hold-off

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    conv2d_valid_int32 dut (.*);

    conv2d_valid_int32_check u_check (.*);

    // receiver: random backpressure plus one long hold-off on request
    always @(posedge aclk) begin
        static int  hold = 0;
        static bit  held = 1'b0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_req && !held) begin
                hold = 600;
                held = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 31);
            end
        end
    end

    function automatic int clamp(int v, int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return {32{1'($urandom_range(1))}};   // zero or minus one
            3, 4, 5: return $urandom_range(512) - 256;
            default: return $urandom;
        endcase
    endfunction

    // one input transfer, with random gaps ahead of it
    task automatic send(logic act, logic [31:0] v);
        while (!calm && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // one register transfer; the caller drops cfg_valid after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // program sizes, load the kernel kloads times, then stream pixels
    task automatic run_phase(int rows, int cols, int kr, int kc, int npix, int kloads);
        int kn;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        write_reg(CFG_IMAGE_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_IMAGE_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_KERNEL_ROWS, CFG_DATA_W'(kr));
        write_reg(CFG_KERNEL_COLS, CFG_DATA_W'(kc));
        cfg_valid <= 1'b0;
        kn = clamp(kr & 15, DEF_MAX_KERNEL_ROWS) * clamp(kc & 15, DEF_MAX_KERNEL_COLS);
        repeat (kloads * kn) send(ACT_KERNEL, pick_value());
        for (int p = 0; p < npix; p++) begin
            // stray kernel items rewrite entries that are already loaded
            if ($urandom_range(99) < 4) send(ACT_KERNEL, pick_value());
            send(ACT_PIXEL, pick_value());
        end
        s_tvalid <= 1'b0;
        phases++;
    endtask

    initial begin
        int rows, cols, kr, kc;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: 1x1 everything, extremes of values, wrap of a tiny image
        run_phase(1, 1, 1, 1, 8, 1);
        // zero registers act as one; kernel loaded twice to exercise its wrap
        run_phase(0, 0, 0, 0, 3, 2);
        // kernel larger than image: pixels go in, nothing comes out
        run_phase(2, 2, 3, 3, 5, 1);
        // maximum encodings: clamp to 4096 rows, 1024 cols, 8 wide kernel
        run_phase(8191, 2047, 1, 15, 40, 1);
        // full 8x8 kernel over a small image, then wrap into the next image
        run_phase(9, 8, 8, 8, 80, 1);

        while (items_sent < ITEM_GOAL) begin
            rows = $urandom_range(1, 6);
            cols = $urandom_range(1, 10);
            kr   = $urandom_range(1, 4);
            kc   = $urandom_range(1, 4);
            if ($urandom_range(9) == 0) kr = $urandom_range(1) ? 0 : 15;
            if ($urandom_range(9) == 0) kc = $urandom_range(1) ? 0 : 12;
            calm = (phases == 12);
            if (phases == 8) stall_req = 1'b1;
            run_phase(rows, cols, kr, kc,
                      $urandom_range(1, 2 * rows * cols + 2), $urandom_range(1, 2));
        end
        calm = 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d phases, %0d input items, %0d results checked",
                 phases, items_sent, results_seen);
        if (fails == 0) begin
            $display("conv2d_valid_int32_test: PASS");
        end else begin
            $display("conv2d_valid_int32_test: FAIL");
        end
        $finish;
    end

    // hard limit well above the slowest correct run
    initial begin
        #30ms;
        $display("timeout with %0d results pending", pending);
        $display("conv2d_valid_int32_test: FAIL");
        $finish;
    end

endmodule
